FILE: sv/rfr_pkg.sv
`default_nettype none
package rfr_pkg;

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic g_set;
      logic div_step;
      logic out_load;
   } rfr_cmd_type;

   typedef struct packed {
      logic spec;
      logic gcd_done;
      logic div_last;
   } rfr_sts_type;

endpackage
`default_nettype wire

FILE: sv/rfr_dpath.sv
`default_nettype none
module rfr_dpath import rfr_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int IN_W       = ((2 * DATA_WIDTH + 7) / 8) * 8,
   parameter int OUT_W      = ((2 * DATA_WIDTH - 1 + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire rfr_cmd_type      cmd,
   output rfr_sts_type           sts,
   input  wire logic [IN_W-1:0]  req_tdata,
   output logic      [OUT_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int W  = DATA_WIDTH;
   localparam int M  = DATA_WIDTH - 1;
   localparam int CW = $clog2(M);
   localparam int PW = OUT_W - (2 * W - 1);

   logic [W-1:0]  n, d, n_mag, d_mag, min_val, q_ext;
   logic          spec_ff, spec_in, err_ff, err_in, neg_ff, neg_in;
   logic [M-1:0]  a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [M-1:0]  qn_ff, qn_in, qd_ff, qd_in, rn_ff, rn_in, rd_ff, rd_in;
   logic [CW-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic [M:0]    shn, shd, difn, difd;
   logic          gen, ged;
   logic [W-1:0]  num_ff, num_in;
   logic [M-1:0]  den_ff, den_in;
   logic          status_ff, status_in;

   assign n       = req_tdata[W-1:0];
   assign d       = req_tdata[2*W-1:W];
   assign min_val = {1'b1, {M{1'b0}}};
   assign n_mag   = n[W-1] ? (~n + 1'b1) : n;
   assign d_mag   = d[W-1] ? (~d + 1'b1) : d;

   assign shn  = {rn_ff, qn_ff[M-1]};
   assign shd  = {rd_ff, qd_ff[M-1]};
   assign difn = shn - {1'b0, g_ff};
   assign difd = shd - {1'b0, g_ff};
   assign gen  = shn >= {1'b0, g_ff};
   assign ged  = shd >= {1'b0, g_ff};
   assign q_ext = {1'b0, qn_ff};

   always_comb begin
      spec_in   = spec_ff;
      err_in    = err_ff;
      neg_in    = neg_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      k_in      = k_ff;
      g_in      = g_ff;
      qn_in     = qn_ff;
      qd_in     = qd_ff;
      rn_in     = rn_ff;
      rd_in     = rd_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      status_in = status_ff;
      priority if (cmd.load) begin
         spec_in = (d == '0) || (n == '0) || (n == min_val) || (d == min_val);
         err_in  = (d == '0) || ((n != '0) && ((n == min_val) || (d == min_val)));
         neg_in  = n[W-1] ^ d[W-1];
         a_in    = n_mag[M-1:0];
         b_in    = d_mag[M-1:0];
         qn_in   = n_mag[M-1:0];
         qd_in   = d_mag[M-1:0];
         k_in    = '0;
      end else if (cmd.gcd_step) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end else if (cmd.g_set) begin
         g_in   = a_ff << k_ff;
         rn_in  = '0;
         rd_in  = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         rn_in  = gen ? difn[M-1:0] : shn[M-1:0];
         rd_in  = ged ? difd[M-1:0] : shd[M-1:0];
         qn_in  = {qn_ff[M-2:0], gen};
         qd_in  = {qd_ff[M-2:0], ged};
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.out_load) begin
         if (spec_ff) begin
            num_in    = '0;
            den_in    = M'(1);
            status_in = err_ff;
         end else begin
            num_in    = neg_ff ? (~q_ext + 1'b1) : q_ext;
            den_in    = qd_ff;
            status_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      spec_ff   <= spec_in;
      err_ff    <= err_in;
      neg_ff    <= neg_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      g_ff      <= g_in;
      qn_ff     <= qn_in;
      qd_ff     <= qd_in;
      rn_ff     <= rn_in;
      rd_ff     <= rd_in;
      cnt_ff    <= cnt_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      status_ff <= status_in;
   end

   assign sts.spec     = spec_ff;
   assign sts.gcd_done = a_ff == b_ff;
   assign sts.div_last = cnt_ff == CW'(M - 1);

   assign rsp_tdata = {{PW{1'b0}}, den_ff, num_ff};
   assign rsp_tuser = status_ff;

endmodule
`default_nettype wire

FILE: sv/rfr_ctrl.sv
`default_nettype none
module rfr_ctrl import rfr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire rfr_sts_type sts,
   output rfr_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GCD  = 3'd1;
   localparam logic [2:0] S_GSET = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       slot_free;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            priority if (sts.spec) begin
               state_in = S_FIN;
            end else if (sts.gcd_done) begin
               state_in = S_GSET;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_GSET: begin
            cmd.g_set = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      priority if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new request taken while one is in progress");

   a_div_not_special: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !sts.spec)
      else $error("division run on a special-case request");

endmodule
`default_nettype wire

FILE: sv/rational_fraction_reduce_unit.sv
// a zero or invalid operand goes straight from accept to the result
// otherwise the unit runs two phases before the result:
// binary gcd up to 2*(DATA_WIDTH-1) steps, then DATA_WIDTH-1 shared divide steps
// one request in flight at a time; a new one is taken while the last result waits,
// but the next result is not written until the last one has been taken
// reset: synchronous active-high, clears the state machine and the result valid flag
`default_nettype none
module rational_fraction_reduce_unit import rfr_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_tvalid,
   output logic                                            req_tready,
   input  wire logic [((2 * DATA_WIDTH + 7) / 8) * 8-1:0] req_tdata,  // num_in, den_in
   output logic                                            rsp_tvalid,
   input  wire logic                                       rsp_tready,
   output logic [((2 * DATA_WIDTH + 6) / 8) * 8-1:0]      rsp_tdata,  // num_out, den_out
   output logic                                            rsp_tuser   // status
);

   localparam int IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int OUT_W = ((2 * DATA_WIDTH + 6) / 8) * 8;

   rfr_cmd_type cmd;
   rfr_sts_type sts;

   rfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   rfr_dpath #(
      .DATA_WIDTH (DATA_WIDTH),
      .IN_W       (IN_W),
      .OUT_W      (OUT_W)
   ) u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: tb/rational_fraction_reduce_unit_tb.sv
`default_nettype none
module rational_fraction_reduce_unit_tb;
   import rfr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 32;
   localparam int IN_W = ((2 * DW + 7) / 8) * 8;
   localparam int OUT_W = ((2 * DW - 1 + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1500;
   localparam int PHASE_ITEMS = 150;
   localparam int DRAIN_CYCLES = 120;
   localparam int unsigned CYCLE_LIMIT = 1_500_000;

   localparam logic STS_OK = 1'b0;
   localparam logic STS_OPERAND_ERR = 1'b1;

   localparam logic [DW-1:0] ZERO = '0;
   localparam logic [DW-1:0] ONE = 1;
   localparam logic [DW-1:0] MINUS_ONE = '1;
   localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW - 1){1'b0}}};
   localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW - 1){1'b1}}};
   localparam logic [DW-1:0] NEG_MAX = {1'b1, {(DW - 2){1'b0}}, 1'b1};
   localparam logic [DW-2:0] DEN_ONE = 1;

   typedef struct packed {
      logic [DW-1:0] num;
      logic [DW-2:0] den;
      logic          status;
   } fraction_type;

   typedef struct packed {
      logic [DW-1:0] num;
      logic [DW-1:0] den;
      logic          typed;
      fraction_type  want;
   } stim_row_type;

   localparam int N_DIRECTED = 23;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [IN_W-1:0]  req_tdata = '0;   // num_in, den_in
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;        // num_out, den_out
   logic             rsp_tuser;        // status

   fraction_type reduced_q[$];
   int unsigned  mismatches = 0;
   int unsigned  cycle_count = 0;
   logic         idle_on = 1'b1;
   logic         stall_on = 1'b1;
   logic [DW-1:0] fib [0:46];

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ZERO, ZERO, 1'b1, '{ZERO, DEN_ONE, STS_OPERAND_ERR}},
      '{32'd7, ZERO, 1'b1, '{ZERO, DEN_ONE, STS_OPERAND_ERR}},
      '{MOST_NEG, ZERO, 1'b1, '{ZERO, DEN_ONE, STS_OPERAND_ERR}},
      '{ZERO, 32'd5, 1'b1, '{ZERO, DEN_ONE, STS_OK}},
      '{ZERO, MOST_NEG, 1'b1, '{ZERO, DEN_ONE, STS_OK}},
      '{ZERO, MINUS_ONE, 1'b1, '{ZERO, DEN_ONE, STS_OK}},
      '{MOST_NEG, 32'd3, 1'b1, '{ZERO, DEN_ONE, STS_OPERAND_ERR}},
      '{32'd5, MOST_NEG, 1'b1, '{ZERO, DEN_ONE, STS_OPERAND_ERR}},
      '{MOST_NEG, MOST_NEG, 1'b1, '{ZERO, DEN_ONE, STS_OPERAND_ERR}},
      '{MOST_POS, MOST_POS, 1'b1, '{ONE, DEN_ONE, STS_OK}},
      '{MOST_POS, ONE, 1'b1, '{MOST_POS, DEN_ONE, STS_OK}},
      '{ONE, MOST_POS, 1'b1, '{ONE, MOST_POS[DW-2:0], STS_OK}},
      '{NEG_MAX, MOST_POS, 1'b1, '{MINUS_ONE, DEN_ONE, STS_OK}},
      '{MOST_POS, MINUS_ONE, 1'b1, '{NEG_MAX, DEN_ONE, STS_OK}},
      '{MINUS_ONE, MINUS_ONE, 1'b1, '{ONE, DEN_ONE, STS_OK}},
      '{ONE, ONE, 1'b1, '{ONE, DEN_ONE, STS_OK}},
      '{NEG_MAX, NEG_MAX, 1'b1, '{ONE, DEN_ONE, STS_OK}},
      '{32'd6, 32'd4, 1'b0, '0},
      '{-32'sd6, 32'd4, 1'b0, '0},
      '{32'd6, -32'sd4, 1'b0, '0},
      '{-32'sd6, -32'sd4, 1'b0, '0},
      '{32'd1836311903, 32'd1134903170, 1'b0, '0},
      '{32'h4000_0000, 32'h0000_8000, 1'b0, '0}
   };

   rational_fraction_reduce_unit #(.DATA_WIDTH(DW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic fraction_type reduce_fraction(logic [DW-1:0] n, logic [DW-1:0] d);
      fraction_type  r;
      logic [DW-1:0] nm, dm, a, b, t;
      r.num = ZERO;
      r.den = DEN_ONE;
      r.status = STS_OK;
      if (d == ZERO) begin
         r.status = STS_OPERAND_ERR;
      end else if (n != ZERO) begin
         if (n == MOST_NEG || d == MOST_NEG) begin
            r.status = STS_OPERAND_ERR;
         end else begin
            nm = n[DW-1] ? -n : n;
            dm = d[DW-1] ? -d : d;
            a = (nm > dm) ? nm : dm;
            b = (nm > dm) ? dm : nm;
            while (b != ZERO) begin
               t = a % b;
               a = b;
               b = t;
            end
            nm = nm / a;
            dm = dm / a;
            r.num = (n[DW-1] ^ d[DW-1]) ? -nm : nm;
            r.den = dm[DW-2:0];
         end
      end
      return r;
   endfunction

   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (!idle_on || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [DW-1:0] with_sign(logic [DW-1:0] v);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic logic [DW-1:0] special_value();
      case ($urandom_range(0, 5))
         0: return ZERO;
         1: return ONE;
         2: return MINUS_ONE;
         3: return MOST_POS;
         4: return MOST_NEG;
         default: return NEG_MAX;
      endcase
   endfunction

   // returns {den, num}
   function automatic logic [2*DW-1:0] random_operands();
      int            pick, k;
      logic [DW-1:0] n, d, g;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         n = $urandom;
         d = $urandom;
      end else if (pick < 50) begin
         g = $urandom_range(1, 1000);
         n = with_sign(g * $urandom_range(0, 2_000_000));
         d = with_sign(g * $urandom_range(1, 2_000_000));
      end else if (pick < 65) begin
         n = with_sign($urandom_range(0, 20));
         d = with_sign($urandom_range(0, 20));
      end else if (pick < 75) begin
         k = $urandom_range(1, 45);
         n = with_sign(fib[k + 1]);
         d = with_sign(fib[k]);
         if ($urandom_range(0, 1)) begin
            g = n;
            n = d;
            d = g;
         end
      end else if (pick < 85) begin
         n = $urandom_range(0, 1) ? special_value() : $urandom;
         d = $urandom_range(0, 1) ? special_value() : $urandom;
      end else begin
         n = with_sign($urandom >> $urandom_range(1, DW - 1));
         d = with_sign($urandom >> $urandom_range(1, DW - 1));
      end
      return {d, n};
   endfunction

   task automatic send_request(logic [DW-1:0] n, logic [DW-1:0] d, fraction_type want);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {d, n};
      do @(posedge clock); while (!req_tready);
      reduced_q.push_back(want);
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (reduced_q.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
      mismatches++;
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
   endtask

   // response checker
   always @(posedge clock) begin
      fraction_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reduced_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[DW-1:0], '0);
         end else begin
            want = reduced_q.pop_front();
            if (rsp_tdata[DW-1:0] !== want.num)
               report_mismatch("num_out", rsp_tdata[DW-1:0], want.num);
            if (rsp_tdata[2*DW-2:DW] !== want.den)
               report_mismatch("den_out", {1'b0, rsp_tdata[2*DW-2:DW]}, {1'b0, want.den});
            if (rsp_tuser !== want.status)
               report_mismatch("status", {{(DW - 1){1'b0}}, rsp_tuser},
                               {{(DW - 1){1'b0}}, want.status});
         end
      end
   end

   // response backpressure
   initial begin
      int hold;
      int pick;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!stall_on) begin
            rsp_tready <= 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               rsp_tready <= 1'b1;
               hold = $urandom_range(0, 3);
            end else if (pick < 95) begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(20, 80);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL rational_fraction_reduce_unit");
         $finish;
      end
   end

   initial begin
      logic [2*DW-1:0] ops;
      stim_row_type    row;
      fib[0] = ONE;
      fib[1] = ONE;
      for (int i = 2; i <= 46; i++) fib[i] = fib[i - 1] + fib[i - 2];

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.num, row.den,
                      row.typed ? row.want : reduce_fraction(row.num, row.den));
      end
      wait_all_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0) begin
            idle_on = ((i / PHASE_ITEMS) % 3 != 0);
            stall_on = ((i / PHASE_ITEMS) % 3 != 0);
            if (i == RANDOM_ITEMS / 2) wait_all_results();
         end
         ops = random_operands();
         send_request(ops[DW-1:0], ops[2*DW-1:DW],
                      reduce_fraction(ops[DW-1:0], ops[2*DW-1:DW]));
      end
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("PASS rational_fraction_reduce_unit");
      end else begin
         $display("FAIL rational_fraction_reduce_unit");
      end
      $finish;
   end

endmodule
`default_nettype wire
